// File: sv/bpe_pkg.sv
package bpe_pkg;

    // Program word fields
    localparam logic [7:0]  OP_SET_PWM = 8'h40;
    localparam logic [2:0]  OP_BRANCH  = 3'b101;  // top bits of 5 << 13
    localparam logic [15:0] MAX_MS     = 16'd60000;

    localparam int unsigned N_CYC     = 7;
    localparam int unsigned IDX_W     = 3;
    localparam int unsigned LOOP_W    = 6;        // loop count never exceeds 61
    localparam int unsigned LEN_W     = 10;
    localparam int unsigned RECIP_W   = 19;
    localparam int unsigned RECIP_SH  = 24;       // reciprocal scale 2^24

    localparam logic [1:0] ENG_RED   = 2'd0;
    localparam logic [1:0] ENG_GREEN = 2'd1;
    localparam logic [1:0] ENG_BLUE  = 2'd2;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    // One decoded blink request, handed from front to back
    typedef struct packed {
        logic [23:0]       color;
        logic              nop;
        logic [7:0]        on_cmd;
        logic [LOOP_W-1:0] on_loop;
        logic [7:0]        off_cmd;
        logic [LOOP_W-1:0] off_loop;
    } t_job;

    typedef enum logic {
        BK_IDLE,
        BK_RUN
    } t_back_state;

    function automatic logic [15:0] cyc_limit(input logic [IDX_W-1:0] idx);
        unique case (idx)
            3'd0:    cyc_limit = 16'd3000;
            3'd1:    cyc_limit = 16'd6000;
            3'd2:    cyc_limit = 16'd10000;
            3'd3:    cyc_limit = 16'd30000;
            3'd4:    cyc_limit = 16'd40000;
            3'd5:    cyc_limit = 16'd50000;
            default: cyc_limit = 16'd60000;
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] cyc_len(input logic [IDX_W-1:0] idx);
        unique case (idx)
            3'd0:    cyc_len = 10'd50;
            3'd1:    cyc_len = 10'd100;
            3'd2:    cyc_len = 10'd200;
            3'd3:    cyc_len = 10'd500;
            3'd4:    cyc_len = 10'd700;
            3'd5:    cyc_len = 10'd920;
            default: cyc_len = 10'd982;
        endcase
    endfunction

    // floor(2^24 / cycle length)
    function automatic logic [RECIP_W-1:0] cyc_recip(input logic [IDX_W-1:0] idx);
        unique case (idx)
            3'd0:    cyc_recip = 19'd335544;
            3'd1:    cyc_recip = 19'd167772;
            3'd2:    cyc_recip = 19'd83886;
            3'd3:    cyc_recip = 19'd33554;
            3'd4:    cyc_recip = 19'd23967;
            3'd5:    cyc_recip = 19'd18236;
            default: cyc_recip = 19'd17084;
        endcase
    endfunction

    function automatic logic [7:0] cyc_cmd(input logic [IDX_W-1:0] idx);
        unique case (idx)
            3'd0:    cyc_cmd = 8'h43;
            3'd1:    cyc_cmd = 8'h46;
            3'd2:    cyc_cmd = 8'h4d;
            3'd3:    cyc_cmd = 8'h60;
            3'd4:    cyc_cmd = 8'h6d;
            3'd5:    cyc_cmd = 8'h7b;
            default: cyc_cmd = 8'h7f;
        endcase
    endfunction

endpackage

// File: sv/bpe_div.sv
// Per-phase wait decode: saturate, pick cycle entry, loop = ms / cycle length.
module bpe_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [15:0]                   i_ms,
    output logic [7:0]                    o_cmd,
    output logic [bpe_pkg::LOOP_W-1:0]    o_loop
);

    logic [15:0]                   n_ms1;
    logic [bpe_pkg::IDX_W-1:0]     n_idx1;
    logic [15:0]                   r_ms1;
    logic [bpe_pkg::IDX_W-1:0]     r_idx1;
    logic [15:0]                   r_ms2;
    logic [bpe_pkg::IDX_W-1:0]     r_idx2;
    logic [bpe_pkg::LOOP_W-1:0]    r_q2;
    logic [bpe_pkg::IDX_W-1:0]     r_idx3;
    logic [bpe_pkg::LOOP_W-1:0]    r_loop3;
    logic [15+bpe_pkg::RECIP_W:0]  w_prod;
    logic [15:0]                   w_back;
    logic [15:0]                   w_rem;
    logic [bpe_pkg::LOOP_W-1:0]    n_loop3;

    // Stage 1: saturate and find the first limit not below the time
    always_comb begin
        n_ms1 = (i_ms > bpe_pkg::MAX_MS) ? bpe_pkg::MAX_MS : i_ms;
        n_idx1 = bpe_pkg::IDX_W'(bpe_pkg::N_CYC - 1);
        for (int i = bpe_pkg::N_CYC - 1; i >= 0; i--) begin
            if (n_ms1 <= bpe_pkg::cyc_limit(bpe_pkg::IDX_W'(i))) begin
                n_idx1 = bpe_pkg::IDX_W'(i);
            end
        end
    end

    // Stage 2: estimate quotient by reciprocal, low by at most one
    assign w_prod = (16+bpe_pkg::RECIP_W)'(r_ms1)
                  * (16+bpe_pkg::RECIP_W)'(bpe_pkg::cyc_recip(r_idx1));

    // Stage 3: back-multiply and correct
    assign w_back = 16'(r_q2) * 16'(bpe_pkg::cyc_len(r_idx2));
    assign w_rem  = r_ms2 - w_back;
    assign n_loop3 = (w_rem >= 16'(bpe_pkg::cyc_len(r_idx2))) ? r_q2 + 1'b1 : r_q2;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ms1   <= n_ms1;
            r_idx1  <= n_idx1;
            r_ms2   <= r_ms1;
            r_idx2  <= r_idx1;
            r_q2    <= w_prod[bpe_pkg::RECIP_SH +: bpe_pkg::LOOP_W];
            r_idx3  <= r_idx2;
            r_loop3 <= n_loop3;
        end
    end

    assign o_cmd  = bpe_pkg::cyc_cmd(r_idx3);
    assign o_loop = r_loop3;

endmodule

// File: sv/bpe_front.sv
// Front: accept requests, flag empty programs, decode both phases (3 stages).
module bpe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [23:0]       i_color,
    input  logic [15:0]       i_on_ms,
    input  logic [15:0]       i_off_ms,
    output logic              o_valid,
    input  logic              i_ready,
    output bpe_pkg::t_job     o_job
);

    logic                          w_move;
    logic                          r_v1;
    logic                          r_v2;
    logic                          r_v3;
    logic [23:0]                   r_color1;
    logic [23:0]                   r_color2;
    logic [23:0]                   r_color3;
    logic                          r_nop1;
    logic                          r_nop2;
    logic                          r_nop3;
    logic [7:0]                    w_on_cmd;
    logic [bpe_pkg::LOOP_W-1:0]    w_on_loop;
    logic [7:0]                    w_off_cmd;
    logic [bpe_pkg::LOOP_W-1:0]    w_off_loop;

    // Advance the whole pipe unless the last stage is held
    assign w_move  = !r_v3 || i_ready;
    assign o_ready = w_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_move) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_move) begin
            r_color1 <= i_color;
            r_nop1   <= (i_color == 24'd0) || (i_on_ms == 16'd0) || (i_off_ms == 16'd0);
            r_color2 <= r_color1;
            r_nop2   <= r_nop1;
            r_color3 <= r_color2;
            r_nop3   <= r_nop2;
        end
    end

    bpe_div u_div_on (
        .i_clk  (i_clk),
        .i_en   (w_move),
        .i_ms   (i_on_ms),
        .o_cmd  (w_on_cmd),
        .o_loop (w_on_loop)
    );

    bpe_div u_div_off (
        .i_clk  (i_clk),
        .i_en   (w_move),
        .i_ms   (i_off_ms),
        .o_cmd  (w_off_cmd),
        .o_loop (w_off_loop)
    );

    assign o_valid = r_v3;
    assign o_job   = {r_color3, r_nop3, w_on_cmd, w_on_loop, w_off_cmd, w_off_loop};

endmodule

// File: sv/bpe_fifo.sv
// Small job queue between front and back, head shown ahead.
module bpe_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  bpe_pkg::t_job               i_data,
    output logic                        o_full,
    input  logic                        i_pop,
    output logic                        o_empty,
    output bpe_pkg::t_job               o_data
);

    bpe_pkg::t_job                  r_mem [bpe_pkg::Q_DEPTH];
    logic [bpe_pkg::Q_PTR_W-1:0]    r_wr;
    logic [bpe_pkg::Q_PTR_W-1:0]    r_rd;
    logic [bpe_pkg::Q_CNT_W-1:0]    r_cnt;

    assign o_full  = (r_cnt == bpe_pkg::Q_CNT_W'(bpe_pkg::Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// File: sv/bpe_back.sv
// Back: walk engines and word addresses of one job, one beat per cycle while the output is not held.
module bpe_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  bpe_pkg::t_job     i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_engine,
    output logic [2:0]        o_word_addr,
    output logic [15:0]       o_program_word,
    output logic              o_no_program,
    output logic              o_last
);

    bpe_pkg::t_back_state r_state;
    bpe_pkg::t_back_state n_state;
    bpe_pkg::t_job        r_job;
    logic [1:0]           r_eng;
    logic [2:0]           r_addr;
    logic                 r_ov;
    logic [1:0]           r_o_eng;
    logic [2:0]           r_o_addr;
    logic [15:0]          r_o_word;
    logic                 r_o_nop;
    logic                 r_o_last;

    logic                 w_adv;
    logic                 w_on_br;
    logic                 w_off_br;
    logic [2:0]           w_off_start;
    logic [2:0]           w_last_addr;
    logic [7:0]           w_byte;
    logic [15:0]          w_word;
    logic                 w_eng_end;
    logic                 w_job_end;
    logic                 w_emit;
    logic                 w_load;
    logic                 w_step_eng;

    assign w_adv = !r_ov || i_ready;

    // Word for the current engine and address
    always_comb begin
        w_on_br     = (r_job.on_loop > bpe_pkg::LOOP_W'(1));
        w_off_br    = (r_job.off_loop > bpe_pkg::LOOP_W'(1));
        w_off_start = 3'd2 + 3'(w_on_br);
        w_last_addr = w_off_start + 3'd1 + 3'(w_off_br);
        unique case (r_eng)
            bpe_pkg::ENG_RED:   w_byte = r_job.color[23:16];
            bpe_pkg::ENG_GREEN: w_byte = r_job.color[15:8];
            default:            w_byte = r_job.color[7:0];
        endcase
        priority if (r_job.nop) begin
            w_word = 16'h0000;
        end else if (r_addr == 3'd0) begin
            w_word = {bpe_pkg::OP_SET_PWM, w_byte};
        end else if (r_addr == 3'd1) begin
            w_word = {r_job.on_cmd, 8'h00};
        end else if (w_on_br && r_addr == 3'd2) begin
            w_word = {bpe_pkg::OP_BRANCH, r_job.on_loop - 1'b1, 4'h0, 3'd0};
        end else if (r_addr == w_off_start) begin
            w_word = {bpe_pkg::OP_SET_PWM, 8'h00};
        end else if (r_addr == w_off_start + 3'd1) begin
            w_word = {r_job.off_cmd, 8'h00};
        end else begin
            w_word = {bpe_pkg::OP_BRANCH, r_job.off_loop - 1'b1, 4'h0, w_off_start};
        end
        w_eng_end = r_job.nop || (r_addr == w_last_addr);
        w_job_end = w_eng_end && (r_job.nop || r_eng == bpe_pkg::ENG_BLUE);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            bpe_pkg::BK_IDLE: begin
                if (!i_empty) begin
                    n_state = bpe_pkg::BK_RUN;
                end
            end
            bpe_pkg::BK_RUN: begin
                if (w_adv && w_job_end && i_empty) begin
                    n_state = bpe_pkg::BK_IDLE;
                end
            end
            default: n_state = bpe_pkg::BK_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        w_emit     = 1'b0;
        w_load     = 1'b0;
        w_step_eng = 1'b0;
        unique case (r_state)
            bpe_pkg::BK_IDLE: begin
                w_load = !i_empty;
            end
            bpe_pkg::BK_RUN: begin
                w_emit     = w_adv;
                w_load     = w_adv && w_job_end && !i_empty;
                w_step_eng = w_adv && w_eng_end && !w_job_end;
            end
            default: ;
        endcase
    end

    assign o_pop = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpe_pkg::BK_IDLE;
            r_ov    <= 1'b0;
            r_eng   <= bpe_pkg::ENG_RED;
            r_addr  <= 3'd0;
        end else begin
            r_state <= n_state;
            if (w_adv) begin
                r_ov <= w_emit;
            end
            if (w_load) begin
                r_eng  <= bpe_pkg::ENG_RED;
                r_addr <= 3'd0;
            end else if (w_step_eng) begin
                r_eng  <= r_eng + 1'b1;
                r_addr <= 3'd0;
            end else if (w_emit) begin
                r_addr <= r_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_job <= i_job;
        end
        if (w_emit) begin
            r_o_eng  <= r_eng;
            r_o_addr <= r_addr;
            r_o_word <= w_word;
            r_o_nop  <= r_job.nop;
            r_o_last <= w_job_end;
        end
    end

    assign o_valid        = r_ov;
    assign o_engine       = r_o_eng;
    assign o_word_addr    = r_o_addr;
    assign o_program_word = r_o_word;
    assign o_no_program   = r_o_nop;
    assign o_last         = r_o_last;

endmodule

// File: sv/led_blink_program_encoder.sv
// A taken request passes the front stages, the job queue, the job register and the
// output register before its first beat. Throughput: one result beat per cycle when
// not stalled; a request yields 12 to 18 beats (one when the colour or a time is
// zero), paced by the back-end word sequencer. A 4-deep job queue decouples the two.
// Reset: i_rst_n is synchronous and active low; it empties the pipe and queue.
module led_blink_program_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,   // color[23:0], on_ms[39:24], off_ms[55:40]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // engine[1:0], word_addr[4:2],
                                        // program_word[20:5], zero[23:21]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser    // no_program
);

    logic          w_f_valid;
    logic          w_q_full;
    logic          w_q_empty;
    logic          w_q_pop;
    bpe_pkg::t_job w_f_job;
    bpe_pkg::t_job w_q_job;
    logic [1:0]    w_engine;
    logic [2:0]    w_word_addr;
    logic [15:0]   w_program_word;

    // Front: saturate times, pick cycle entries and divide in three stages
    bpe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_color  (s_axis_tdata[23:0]),
        .i_on_ms  (s_axis_tdata[39:24]),
        .i_off_ms (s_axis_tdata[55:40]),
        .o_valid  (w_f_valid),
        .i_ready  (!w_q_full),
        .o_job    (w_f_job)
    );

    // Hold decoded jobs until the sequencer is free
    bpe_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid && !w_q_full),
        .i_data  (w_f_job),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_empty (w_q_empty),
        .o_data  (w_q_job)
    );

    // Back: emit red, green, blue programs word by word
    bpe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_q_empty),
        .i_job          (w_q_job),
        .o_pop          (w_q_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_engine       (w_engine),
        .o_word_addr    (w_word_addr),
        .o_program_word (w_program_word),
        .o_no_program   (m_axis_tuser),
        .o_last         (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, w_program_word, w_word_addr, w_engine};

    // A no-program beat stands alone
    a_nop_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && m_axis_tdata == 24'd0)
        else $error("no-program beat not alone");

    // A built program ends on the blue engine
    a_last_blue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast && !m_axis_tuser
        |-> m_axis_tdata[1:0] == bpe_pkg::ENG_BLUE)
        else $error("program ends on wrong engine");

    // Word address stays within a six-word program and engine within three
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[4:2] != 3'd6 && m_axis_tdata[4:2] != 3'd7
                          && m_axis_tdata[1:0] != 2'd3)
        else $error("word address or engine out of range");

    // Queue never popped while empty
    a_queue_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_q_pop && w_q_empty))
        else $error("job queue underflow");

endmodule
